[design/tccs_pkg.sv]
// package for the text console writer: field widths, character codes, result record
// no dependencies; imported by tccs_seq and the top level

package tccs_pkg;

    // default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 24;

    // fixed field widths of the ports
    localparam int OP_W   = 1;
    localparam int CODE_W = 9;
    localparam int POS_W  = 11;
    localparam int ATTR_W = 8;
    localparam int CHAR_W = 8;
    localparam int CELL_W = ATTR_W + CHAR_W;

    // operations
    localparam logic [OP_W-1:0] OP_PUT  = 1'b0;
    localparam logic [OP_W-1:0] OP_READ = 1'b1;

    // character codes with a meaning of their own
    localparam logic [CODE_W-1:0] CODE_NEWLINE   = 9'd10;
    localparam logic [CODE_W-1:0] CODE_BACKSPACE = 9'h100;
    localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'h20;

    // attribute after reset: light grey on black
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

    // one finished result handed from the sequencer to the output register
    typedef struct packed {
        logic              load;
        logic [POS_W-1:0]  cursor_position;
        logic [CELL_W-1:0] cell_data;
    } tccs_result_t;

endpackage

[design/tccs_ram.sv]
// generic single-write, single-read memory with registered read data
// no dependencies; holds the screen cells

module tccs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1920,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[design/tccs_seq.sv]
// sequencer of the text console writer: cursor, cell address counter and memory port
// depends on tccs_pkg; drives one tccs_ram instance in the top level

module tccs_seq #(
    parameter int COLUMNS = tccs_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccs_pkg::ROWS_DEF,
    localparam int AW     = $clog2(COLUMNS * ROWS)
) (
    input  logic                          clk,
    input  logic                          rstn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tccs_pkg::OP_W-1:0]     opcode,
    input  logic [tccs_pkg::CODE_W-1:0]   char_code,
    input  logic [tccs_pkg::POS_W-1:0]    read_address,
    input  logic [tccs_pkg::ATTR_W-1:0]   text_attribute,
    input  logic                          res_ready,
    output tccs_pkg::tccs_result_t        res,
    output logic                          ram_wr_en,
    output logic [AW-1:0]                 ram_wr_addr,
    output logic [tccs_pkg::CELL_W-1:0]   ram_wr_data,
    output logic                          ram_rd_en,
    output logic [AW-1:0]                 ram_rd_addr,
    input  logic [tccs_pkg::CELL_W-1:0]   ram_rd_data
);

    import tccs_pkg::*;

    localparam int CELLS     = COLUMNS * ROWS;
    localparam int CW        = $clog2(COLUMNS);
    localparam int LAST_COPY = CELLS - COLUMNS - 1;

    typedef enum logic [7:0] {
        ST_CLEAR   = 8'b0000_0001,
        ST_IDLE    = 8'b0000_0010,
        ST_RD_WAIT = 8'b0000_0100,
        ST_PUT     = 8'b0000_1000,
        ST_SCR_RD  = 8'b0001_0000,
        ST_SCR_WR  = 8'b0010_0000,
        ST_ZERO    = 8'b0100_0000,
        ST_RESP    = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [AW-1:0]       cursor_reg, cursor_next;
    logic [CW-1:0]       col_reg, col_next;
    logic [CODE_W-1:0]   code_reg, code_next;
    logic                oob_reg, oob_next;
    logic [CELL_W-1:0]   cell_reg, cell_next;

    logic                in_oob;
    logic                is_nl;
    logic                is_bs;
    logic [AW:0]         cur_ext;
    logic [AW:0]         cur_step;
    logic [CW-1:0]       col_step;

    assign in_oob = 32'(read_address) >= 32'(CELLS);
    assign is_nl  = code_reg == CODE_NEWLINE;
    assign is_bs  = code_reg == CODE_BACKSPACE;
    assign cur_ext = {1'b0, cursor_reg};

    // cursor move of a put, column kept alongside so no divide is needed
    always_comb begin
        if (is_nl) begin
            cur_step = cur_ext + ((AW+1)'(COLUMNS) - (AW+1)'(col_reg));
            col_step = '0;
        end else if (is_bs) begin
            if (cursor_reg == '0) begin
                cur_step = '0;
                col_step = '0;
            end else begin
                cur_step = cur_ext - (AW+1)'(1);
                col_step = (col_reg == '0) ? CW'(COLUMNS - 1) : col_reg - CW'(1);
            end
        end else begin
            cur_step = cur_ext + (AW+1)'(1);
            col_step = (col_reg == CW'(COLUMNS - 1)) ? '0 : col_reg + CW'(1);
        end
    end

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        cursor_next = cursor_reg;
        col_next    = col_reg;
        code_next   = code_reg;
        oob_next    = oob_reg;
        cell_next   = cell_reg;

        in_ready    = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = idx_reg;
        ram_wr_data = '0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = idx_reg + AW'(COLUMNS);

        res.load            = 1'b0;
        res.cursor_position = POS_W'(cursor_reg);
        res.cell_data       = cell_reg;

        case (state_reg)
            ST_CLEAR: begin
                ram_wr_en = 1'b1;
                if (idx_reg == AW'(CELLS - 1)) begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_IDLE: begin
                in_ready    = 1'b1;
                ram_rd_addr = AW'(read_address);
                ram_rd_en   = in_valid && (opcode == OP_READ) && !in_oob;
                if (in_valid) begin
                    code_next  = char_code;
                    oob_next   = in_oob;
                    state_next = (opcode == OP_READ) ? ST_RD_WAIT : ST_PUT;
                end
            end
            ST_RD_WAIT: begin
                cell_next  = oob_reg ? '0 : ram_rd_data;
                state_next = ST_RESP;
            end
            ST_PUT: begin
                cell_next   = '0;
                ram_wr_en   = !is_nl;
                ram_wr_addr = is_bs ? cur_step[AW-1:0] : cursor_reg;
                ram_wr_data = {text_attribute, is_bs ? BLANK_CHAR : code_reg[CHAR_W-1:0]};
                col_next    = col_step;
                if (cur_step == (AW+1)'(CELLS)) begin
                    cursor_next = AW'(CELLS - COLUMNS);
                    idx_next    = '0;
                    state_next  = ST_SCR_RD;
                end else begin
                    cursor_next = cur_step[AW-1:0];
                    state_next  = ST_RESP;
                end
            end
            ST_SCR_RD: begin
                // fetch the cell one row below
                ram_rd_en  = 1'b1;
                state_next = ST_SCR_WR;
            end
            ST_SCR_WR: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = ram_rd_data;
                if (idx_reg == AW'(LAST_COPY)) begin
                    idx_next   = AW'(CELLS - COLUMNS);
                    state_next = ST_ZERO;
                end else begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = ST_SCR_RD;
                end
            end
            ST_ZERO: begin
                ram_wr_en = 1'b1;
                if (idx_reg == AW'(CELLS - 1)) begin
                    idx_next   = '0;
                    state_next = ST_RESP;
                end else begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_RESP: begin
                res.load = res_ready;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
                idx_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg  <= ST_CLEAR;
            idx_reg    <= '0;
            cursor_reg <= '0;
            col_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            cursor_reg <= cursor_next;
            col_reg    <= col_next;
        end
    end

    always_ff @(posedge clk) begin
        code_reg <= code_next;
        oob_reg  <= oob_next;
        cell_reg <= cell_next;
    end

endmodule

[design/text_console_cursor_scroll_top.sv]
// text console writer top level: attribute register, output register, sequencer and screen memory
// depends on tccs_pkg, tccs_seq and tccs_ram

// Text-mode console writer. The screen is COLUMNS x ROWS cells of 16 bits
// (attribute byte high, character low) in one single-port-write memory, and
// a linear cursor. After reset the block runs a clearing pass over all
// COLUMNS*ROWS cells (1920 by default) during which s_ready stays low;
// cfg writes are taken at any time. A put or a read keeps the block busy
// through the transfer cycle (which also issues the memory read of a read),
// a step to write or capture the cell, and a step to hand the result to the
// output register, which waits while that register is full. A put that
// runs the cursor off the last row scrolls: each of the (ROWS-1)*COLUMNS
// cells is moved up with a read step and a write step through the same
// memory port pair, then the last row is zeroed one cell a cycle. The
// memory port pair is the shared unit that all of these steps go through.
// One item is in flight at a time; a finished result sits in the output
// register, so the next item can be taken while the result waits for
// m_ready.

module text_console_cursor_scroll_top #(
    parameter int COLUMNS = tccs_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccs_pkg::ROWS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // attribute register write
    input  logic                          cfg_wr_en,
    input  logic [tccs_pkg::ATTR_W-1:0]   cfg_wr_data,
    // input items
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tccs_pkg::OP_W-1:0]     s_opcode,
    input  logic [tccs_pkg::CODE_W-1:0]   s_char_code,
    input  logic [tccs_pkg::POS_W-1:0]    s_read_address,
    // results
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tccs_pkg::POS_W-1:0]    m_cursor_position,
    output logic [tccs_pkg::CELL_W-1:0]   m_cell_data
);

    import tccs_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    logic [ATTR_W-1:0]  attr_reg;
    logic               m_valid_reg;
    logic [POS_W-1:0]   m_cursor_position_reg;
    logic [CELL_W-1:0]  m_cell_data_reg;

    tccs_result_t       res;
    logic               res_ready;

    logic               ram_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    logic [CELL_W-1:0]  ram_wr_data;
    logic               ram_rd_en;
    logic [AW-1:0]      ram_rd_addr;
    logic [CELL_W-1:0]  ram_rd_data;

    // output slot is free when empty or being drained this cycle
    assign res_ready = !m_valid_reg || m_ready;

    // attribute byte, written without handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg <= ATTR_RESET;
        end else if (cfg_wr_en) begin
            attr_reg <= cfg_wr_data;
        end
    end

    // output register between the sequencer and the result channel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.load) begin
            m_cursor_position_reg <= res.cursor_position;
            m_cell_data_reg       <= res.cell_data;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_cursor_position = m_cursor_position_reg;
    assign m_cell_data       = m_cell_data_reg;

    // cursor, scroll and clear sequencing
    tccs_seq #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_seq (
        .clk            (aclk),
        .rstn           (aresetn),
        .in_valid       (s_valid),
        .in_ready       (s_ready),
        .opcode         (s_opcode),
        .char_code      (s_char_code),
        .read_address   (s_read_address),
        .text_attribute (attr_reg),
        .res_ready      (res_ready),
        .res            (res),
        .ram_wr_en      (ram_wr_en),
        .ram_wr_addr    (ram_wr_addr),
        .ram_wr_data    (ram_wr_data),
        .ram_rd_en      (ram_rd_en),
        .ram_rd_addr    (ram_rd_addr),
        .ram_rd_data    (ram_rd_data)
    );

    // screen cell store
    tccs_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

[design/tccs_checker.sv]
// port-level checks for the text console writer
// depends on tccs_pkg; bound to text_console_cursor_scroll_top

module tccs_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [tccs_pkg::POS_W-1:0]    m_cursor_position,
    input logic [tccs_pkg::CELL_W-1:0]   m_cell_data
);

    // clearing pass holds off input right after reset
    assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("input taken during clearing pass");

    // one item at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item taken while one is in flight");

    // no result can appear the cycle after a transfer in
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !$rose(m_valid))
        else $error("result appeared too early");

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_cursor_position)
                                   && $stable(m_cell_data)))
        else $error("stalled result changed");

endmodule

bind text_console_cursor_scroll_top tccs_checker u_tccs_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_cursor_position (m_cursor_position),
    .m_cell_data       (m_cell_data)
);
